// ===== hw/rtl/fcp_pkg.sv =====
// Shared types and constants for the canonical field-element packer.
`default_nettype none

package fcp_pkg;

  localparam int unsigned LimbW      = 64;
  localparam int unsigned LimbBits   = 51;
  localparam int unsigned CarryW     = LimbW - LimbBits;
  localparam int unsigned NumLimbs   = 5;
  localparam int unsigned FoldFactor = 19;
  localparam int unsigned FoldW      = CarryW + 5;
  localparam int unsigned ValueW     = NumLimbs * LimbBits;
  localparam int unsigned LowW       = 128;
  localparam int unsigned HighW      = ValueW - LowW;
  localparam int unsigned WordW      = 64;
  localparam int unsigned TopWordW   = ValueW - 3 * WordW;
  // Weight of the spare limb-one carry bit in the packed value.
  localparam int unsigned SpareShift = 2 * LimbBits;

  typedef logic [LimbW-1:0] limb_t;
  typedef limb_t [NumLimbs-1:0] limbs_t;

  typedef struct packed {
    logic [LimbW-1:0] limb4;
    logic [LimbW-1:0] limb3;
    logic [LimbW-1:0] limb2;
    logic [LimbW-1:0] limb1;
    logic [LimbW-1:0] limb0;
  } in_item_t;

  typedef struct packed {
    logic [TopWordW-1:0] word3;
    logic [WordW-1:0]    word2;
    logic [WordW-1:0]    word1;
    logic [WordW-1:0]    word0;
  } out_item_t;

  // Packed value with all limbs reduced to 51 bits, plus the one bit
  // that limb one may still carry into weight 2^102.
  typedef struct packed {
    logic [ValueW-1:0] packed_val;
    logic              spare;
  } fold_t;

  // Low half done both ways: as is, and with 19 added.
  typedef struct packed {
    logic [HighW-1:0] p_hi;
    logic [LowW-1:0]  lo_v;
    logic [LowW-1:0]  lo_w;
    logic             carry_v;
    logic             carry_w;
  } low_t;

endpackage

`default_nettype wire

// ===== hw/rtl/curve25519_field_canonical_pack_core.sv =====
// Top level of the canonical GF(2^255-19) packer, radix 2^51 limbs to 255 bits.
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i / in_stall_o  fcp_pkg::in_item_t  (limb0..limb4)
// out       source     out_valid_o / out_stall_i fcp_pkg::out_item_t (word0..word3)
//
// Seven register stages: four carry steps of the first pass, the fold of the
// top carry, the low 128-bit add, and the high add with the final select.
// One item per cycle sustained while out_stall_i stays low.
// Reset clears only the stage valid bits; payload registers are left as is.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// collapse under out_stall_i and new items enter while a result waits.

module curve25519_field_canonical_pack_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fcp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fcp_pkg::out_item_t out_data_o
);

  localparam int unsigned NumCarry = fcp_pkg::NumLimbs - 1;

  logic            c_valid [NumCarry+1];
  logic            c_ready [NumCarry+1];
  fcp_pkg::limbs_t c_limbs [NumCarry+1];

  logic            fold_valid;
  logic            fold_ready;
  fcp_pkg::fold_t  fold;
  logic            low_valid;
  logic            low_ready;
  fcp_pkg::low_t   low;

  // Unpack the input item into the limb vector of the first carry stage.
  assign c_valid[0]    = in_valid_i;
  assign c_limbs[0][0] = in_data_i.limb0;
  assign c_limbs[0][1] = in_data_i.limb1;
  assign c_limbs[0][2] = in_data_i.limb2;
  assign c_limbs[0][3] = in_data_i.limb3;
  assign c_limbs[0][4] = in_data_i.limb4;
  assign in_stall_o    = !c_ready[0];

  // Each step carries position 0 into position 1 and rotates, so every
  // instance is the same; after four steps the carried limb 4 sits first.
  for (genvar i = 0; i < NumCarry; i++) begin : g_carry
    fcp_carry_stage u_carry (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[i]),
      .ready_o (c_ready[i]),
      .limbs_i (c_limbs[i]),
      .valid_o (c_valid[i+1]),
      .ready_i (c_ready[i+1]),
      .limbs_o (c_limbs[i+1])
    );
  end

  fcp_fold_stage u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid[NumCarry]),
    .ready_o (c_ready[NumCarry]),
    .limbs_i (c_limbs[NumCarry]),
    .valid_o (fold_valid),
    .ready_i (fold_ready),
    .fold_o  (fold)
  );

  fcp_low_add_stage u_low (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fold_valid),
    .ready_o (fold_ready),
    .fold_i  (fold),
    .valid_o (low_valid),
    .ready_i (low_ready),
    .low_o   (low)
  );

  fcp_high_sel_stage u_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (low_valid),
    .ready_o (low_ready),
    .low_i   (low),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .item_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fcp_carry_stage.sv =====
// One carry step of the first pass: limb 0 into limb 1, then rotate the limbs.
`default_nettype none

module fcp_carry_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fcp_pkg::limbs_t limbs_i,
  output logic            valid_o,
  input  logic            ready_i,
  output fcp_pkg::limbs_t limbs_o
);

  logic            valid_q;
  fcp_pkg::limbs_t limbs_d;
  fcp_pkg::limbs_t limbs_q;

  // Carry into the next limb (wraps at 64 bits), park the masked limb at the top.
  always_comb begin
    limbs_d    = limbs_i;
    limbs_d[0] = limbs_i[1] + fcp_pkg::LimbW'(limbs_i[0][fcp_pkg::LimbW-1:fcp_pkg::LimbBits]);
    limbs_d[1] = limbs_i[2];
    limbs_d[2] = limbs_i[3];
    limbs_d[3] = limbs_i[4];
    limbs_d[4] = fcp_pkg::LimbW'(limbs_i[0][fcp_pkg::LimbBits-1:0]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      limbs_q <= limbs_d;
    end
  end

  assign valid_o = valid_q;
  assign limbs_o = limbs_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcp_fold_stage.sv =====
// Fold the top carry back times 19, carry once into limb one, pack the value.
`default_nettype none

module fcp_fold_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fcp_pkg::limbs_t limbs_i,
  output logic            valid_o,
  input  logic            ready_i,
  output fcp_pkg::fold_t  fold_o
);

  logic                         valid_q;
  logic [fcp_pkg::CarryW-1:0]   top;
  logic [fcp_pkg::FoldW-1:0]    fold_add;
  logic [fcp_pkg::LimbBits:0]   t0;
  logic [fcp_pkg::LimbBits:0]   t1;
  fcp_pkg::fold_t               fold_d;
  fcp_pkg::fold_t               fold_q;

  // After four rotations: [0] = carried limb 4, [1..4] = masked limbs 0..3.
  always_comb begin
    top      = limbs_i[0][fcp_pkg::LimbW-1:fcp_pkg::LimbBits];
    fold_add = fcp_pkg::FoldW'(top) * fcp_pkg::FoldW'(fcp_pkg::FoldFactor);
    t0       = (fcp_pkg::LimbBits+1)'(limbs_i[1][fcp_pkg::LimbBits-1:0])
             + (fcp_pkg::LimbBits+1)'(fold_add);
    t1       = (fcp_pkg::LimbBits+1)'(limbs_i[2][fcp_pkg::LimbBits-1:0])
             + (fcp_pkg::LimbBits+1)'(t0[fcp_pkg::LimbBits]);
    fold_d.packed_val = {limbs_i[0][fcp_pkg::LimbBits-1:0],
                         limbs_i[4][fcp_pkg::LimbBits-1:0],
                         limbs_i[3][fcp_pkg::LimbBits-1:0],
                         t1[fcp_pkg::LimbBits-1:0],
                         t0[fcp_pkg::LimbBits-1:0]};
    fold_d.spare      = t1[fcp_pkg::LimbBits];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      fold_q <= fold_d;
    end
  end

  assign valid_o = valid_q;
  assign fold_o  = fold_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcp_low_add_stage.sv =====
// Low 128 bits of the value: plain and with 19 added, carries kept.
`default_nettype none

module fcp_low_add_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  fcp_pkg::fold_t fold_i,
  output logic           valid_o,
  input  logic           ready_i,
  output fcp_pkg::low_t  low_o
);

  logic                    valid_q;
  logic [fcp_pkg::LowW:0]  base;
  logic [fcp_pkg::LowW:0]  spare_term;
  logic [fcp_pkg::LowW:0]  sum_v;
  logic [fcp_pkg::LowW:0]  sum_w;
  fcp_pkg::low_t           low_d;
  fcp_pkg::low_t           low_q;

  // The spare bit and 19 sit in disjoint bits, so both sums are single adds.
  always_comb begin
    base       = (fcp_pkg::LowW+1)'(fold_i.packed_val[fcp_pkg::LowW-1:0]);
    spare_term = (fcp_pkg::LowW+1)'(fold_i.spare) << fcp_pkg::SpareShift;
    sum_v = base + spare_term;
    sum_w = base + (spare_term | (fcp_pkg::LowW+1)'(fcp_pkg::FoldFactor));
    low_d.p_hi    = fold_i.packed_val[fcp_pkg::ValueW-1:fcp_pkg::LowW];
    low_d.lo_v    = sum_v[fcp_pkg::LowW-1:0];
    low_d.lo_w    = sum_w[fcp_pkg::LowW-1:0];
    low_d.carry_v = sum_v[fcp_pkg::LowW];
    low_d.carry_w = sum_w[fcp_pkg::LowW];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      low_q <= low_d;
    end
  end

  assign valid_o = valid_q;
  assign low_o   = low_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcp_high_sel_stage.sv =====
// High half, quotient bit and choice of the canonical value; output register.
`default_nettype none

module fcp_high_sel_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fcp_pkg::low_t     low_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fcp_pkg::out_item_t item_o
);

  logic                       valid_q;
  logic [fcp_pkg::HighW:0]    hi_v;
  logic [fcp_pkg::HighW:0]    hi_w;
  logic                       quot;
  logic [fcp_pkg::ValueW-1:0] canon;
  fcp_pkg::out_item_t         item_d;
  fcp_pkg::out_item_t         item_q;

  always_comb begin
    hi_v  = (fcp_pkg::HighW+1)'(low_i.p_hi) + (fcp_pkg::HighW+1)'(low_i.carry_v);
    hi_w  = (fcp_pkg::HighW+1)'(low_i.p_hi) + (fcp_pkg::HighW+1)'(low_i.carry_w);
    // Value plus 19 reaches 2^255: take that sum, bit 255 dropped.
    quot  = hi_w[fcp_pkg::HighW];
    canon = quot ? {hi_w[fcp_pkg::HighW-1:0], low_i.lo_w}
                 : {hi_v[fcp_pkg::HighW-1:0], low_i.lo_v};
    item_d.word0 = canon[fcp_pkg::WordW-1:0];
    item_d.word1 = canon[2*fcp_pkg::WordW-1:fcp_pkg::WordW];
    item_d.word2 = canon[3*fcp_pkg::WordW-1:2*fcp_pkg::WordW];
    item_d.word3 = canon[fcp_pkg::ValueW-1:3*fcp_pkg::WordW];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire
